// ===== sv/glyph_substitution_tally_unit_assert.svh =====
// Assertion macros shared by the glyph substitution tally RTL.
`ifndef GLYPH_SUBSTITUTION_TALLY_UNIT_ASSERT_SVH
`define GLYPH_SUBSTITUTION_TALLY_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define GST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gst: same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define GST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gst: next-cycle check failed");

`endif

// ===== sv/gst_pkg.sv =====
// Shared constants, types and helpers for the glyph substitution tally.
`default_nettype none

package gst_pkg;

    localparam int MISS_ENTRIES = 64;
    localparam int SIZE_ENTRIES = 8;

    localparam int MISS_IDX_W = (MISS_ENTRIES > 1) ? $clog2(MISS_ENTRIES) : 1;
    localparam int MISS_CNT_W = $clog2(MISS_ENTRIES + 1);
    localparam int SIZE_IDX_W = (SIZE_ENTRIES > 1) ? $clog2(SIZE_ENTRIES) : 1;
    localparam int SIZE_CNT_W = $clog2(SIZE_ENTRIES + 1);

    localparam int CODE_W     = 16;
    localparam int CNT_W      = 32;
    localparam int SLOT_W     = 6;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 192;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSTITUTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALT       = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_REQUEST   = 2'd0,
        MODE_MISS_READ = 2'd1,
        MODE_SIZE_READ = 2'd2
    } gst_mode_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  count;
    } miss_entry_t;

    typedef struct packed {
        logic [CODE_W-1:0] substitute_code;
        logic [CODE_W-1:0] none_code;
        logic              halt_on_missing;
    } cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0]     glyph_index;
        logic                  substituted;
        logic                  fatal_miss;
        logic [CNT_W-1:0]      drawn_total;
        logic [CNT_W-1:0]      missing_total;
        logic [MISS_CNT_W-1:0] missing_distinct;
        logic [CNT_W-1:0]      missing_overflow;
        logic                  entry_valid;
        logic [CODE_W-1:0]     entry_code;
        logic [CNT_W-1:0]      entry_count;
        logic [CODE_W-1:0]     font_size_value;
        logic [SIZE_CNT_W-1:0] font_sizes_used;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== sv/gst_miss_ram.sv =====
// Miss table memory: code and count per entry, one write and one registered read port.
`default_nettype none

module gst_miss_ram (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic [gst_pkg::MISS_IDX_W-1:0] waddr,
    input  wire gst_pkg::miss_entry_t           wdata,
    input  wire logic                           re,
    input  wire logic [gst_pkg::MISS_IDX_W-1:0] raddr,
    output gst_pkg::miss_entry_t                rdata
);

    gst_pkg::miss_entry_t entry_mem [gst_pkg::MISS_ENTRIES];
    gst_pkg::miss_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= entry_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/gst_size_set.sv =====
// Small set of distinct font glyph counts, filled in arrival order.
`default_nettype none

module gst_size_set (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           note_en,
    input  wire logic [gst_pkg::CODE_W-1:0]     note_value,
    input  wire logic [gst_pkg::SLOT_W-1:0]     rd_slot,
    output logic                                rd_valid,
    output logic [gst_pkg::CODE_W-1:0]          rd_value,
    output logic [gst_pkg::SIZE_CNT_W-1:0]      used_count
);

    logic [gst_pkg::CODE_W-1:0]     sizes_reg [gst_pkg::SIZE_ENTRIES];
    logic [gst_pkg::SIZE_CNT_W-1:0] count_reg;
    logic [gst_pkg::SIZE_CNT_W-1:0] count_next;
    logic                           found;
    logic                           insert;

    // parallel match over the filled entries
    always_comb
    begin
        found = 1'b0;
        for (int i = 0; i < gst_pkg::SIZE_ENTRIES; i++)
        begin
            if ((gst_pkg::SIZE_CNT_W'(i) < count_reg) && (sizes_reg[i] == note_value))
            begin
                found = 1'b1;
            end
        end
    end

    assign insert = note_en && !found
                    && (count_reg < gst_pkg::SIZE_CNT_W'(gst_pkg::SIZE_ENTRIES));
    assign count_next = insert ? count_reg + gst_pkg::SIZE_CNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            sizes_reg[gst_pkg::SIZE_IDX_W'(count_reg)] <= note_value;
        end
    end

    assign rd_valid   = rd_slot < gst_pkg::SLOT_W'(count_reg);
    assign rd_value   = rd_valid ? sizes_reg[gst_pkg::SIZE_IDX_W'(rd_slot)] : '0;
    assign used_count = count_reg;

endmodule

`default_nettype wire

// ===== sv/gst_ctrl.sv =====
// Sequencer: request decode, miss table scan with read-modify-write, totals.
`default_nettype none
`include "glyph_substitution_tally_unit_assert.svh"

module gst_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [gst_pkg::MODE_W-1:0]     in_mode,
    input  wire logic [gst_pkg::CODE_W-1:0]     in_code,
    input  wire logic [gst_pkg::CODE_W-1:0]     in_glyphs,
    input  wire logic [gst_pkg::SLOT_W-1:0]     in_slot,
    input  wire gst_pkg::cfg_t                  cfg,
    input  wire logic                           out_free,
    output logic                                res_push,
    output gst_pkg::result_t                    res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RDWAIT,
        ST_FIN
    } state_t;

    state_t                         state_reg, state_next;
    logic [gst_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [gst_pkg::CODE_W-1:0]     code_reg, code_next;
    logic [gst_pkg::CODE_W-1:0]     glyphs_reg, glyphs_next;
    logic [gst_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [gst_pkg::MISS_IDX_W-1:0] idx_reg, idx_next;
    logic [gst_pkg::MISS_CNT_W-1:0] used_reg, used_next;
    logic [gst_pkg::CNT_W-1:0]      req_cnt_reg, req_cnt_next;
    logic [gst_pkg::CNT_W-1:0]      miss_tot_reg, miss_tot_next;
    logic [gst_pkg::CNT_W-1:0]      ovf_reg, ovf_next;

    logic [gst_pkg::CODE_W-1:0]     glyph_reg, glyph_next;
    logic                           subst_reg, subst_next;
    logic                           fatal_reg, fatal_next;
    logic                           evalid_reg, evalid_next;
    logic [gst_pkg::CODE_W-1:0]     ecode_reg, ecode_next;
    logic [gst_pkg::CNT_W-1:0]      ecount_reg, ecount_next;
    logic [gst_pkg::CODE_W-1:0]     fsize_reg, fsize_next;

    logic                           ram_we, ram_re;
    logic [gst_pkg::MISS_IDX_W-1:0] ram_waddr, ram_raddr;
    gst_pkg::miss_entry_t           ram_wdata, ram_rdata;

    logic                           size_note;
    logic                           size_rd_valid;
    logic [gst_pkg::CODE_W-1:0]     size_rd_value;
    logic [gst_pkg::SIZE_CNT_W-1:0] size_used;

    logic                           hit;
    logic                           last_entry;
    logic                           table_full;

    gst_miss_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gst_size_set u_sizes (
        .clk        (clk),
        .rst_n      (rst_n),
        .note_en    (size_note),
        .note_value (glyphs_reg),
        .rd_slot    (slot_reg),
        .rd_valid   (size_rd_valid),
        .rd_value   (size_rd_value),
        .used_count (size_used)
    );

    // code zero never has a glyph, whatever none_code says
    assign hit = (code_reg != '0) && (code_reg != cfg.none_code) && (code_reg <= glyphs_reg);
    assign last_entry = (gst_pkg::MISS_CNT_W'(idx_reg) + gst_pkg::MISS_CNT_W'(1)) == used_reg;
    assign table_full = used_reg == gst_pkg::MISS_CNT_W'(gst_pkg::MISS_ENTRIES);

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        code_next     = code_reg;
        glyphs_next   = glyphs_reg;
        slot_next     = slot_reg;
        idx_next      = idx_reg;
        used_next     = used_reg;
        req_cnt_next  = req_cnt_reg;
        miss_tot_next = miss_tot_reg;
        ovf_next      = ovf_reg;
        glyph_next    = glyph_reg;
        subst_next    = subst_reg;
        fatal_next    = fatal_reg;
        evalid_next   = evalid_reg;
        ecode_next    = ecode_reg;
        ecount_next   = ecount_reg;
        fsize_next    = fsize_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        size_note     = 1'b0;
        res_push      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next   = in_mode;
                    code_next   = in_code;
                    glyphs_next = in_glyphs;
                    slot_next   = in_slot;
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                glyph_next  = '0;
                subst_next  = 1'b0;
                fatal_next  = 1'b0;
                evalid_next = 1'b0;
                ecode_next  = '0;
                ecount_next = '0;
                fsize_next  = '0;
                state_next  = ST_FIN;
                unique case (gst_pkg::gst_mode_t'(mode_reg))
                    gst_pkg::MODE_REQUEST:
                    begin
                        size_note    = 1'b1;
                        req_cnt_next = gst_pkg::sat_inc(req_cnt_reg);
                        if (hit)
                        begin
                            glyph_next = code_reg - gst_pkg::CODE_W'(1);
                        end
                        else
                        begin
                            glyph_next    = cfg.substitute_code - gst_pkg::CODE_W'(1);
                            subst_next    = 1'b1;
                            fatal_next    = cfg.halt_on_missing;
                            miss_tot_next = gst_pkg::sat_inc(miss_tot_reg);
                            if (used_reg == '0)
                            begin
                                // empty table: first entry straight away
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = '{code: code_reg, count: gst_pkg::CNT_W'(1)};
                                used_next = gst_pkg::MISS_CNT_W'(1);
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    gst_pkg::MODE_MISS_READ:
                    begin
                        if (gst_pkg::MISS_CNT_W'(slot_reg) < used_reg)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = gst_pkg::MISS_IDX_W'(slot_reg);
                            state_next = ST_RDWAIT;
                        end
                    end
                    gst_pkg::MODE_SIZE_READ:
                    begin
                        evalid_next = size_rd_valid;
                        fsize_next  = size_rd_value;
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end

            ST_SCAN:
            begin
                // one entry compared per cycle; the next read is issued alongside
                if (ram_rdata.code == code_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = idx_reg;
                    ram_wdata  = '{code: code_reg, count: gst_pkg::sat_inc(ram_rdata.count)};
                    state_next = ST_FIN;
                end
                else if (last_entry)
                begin
                    if (!table_full)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = gst_pkg::MISS_IDX_W'(used_reg);
                        ram_wdata = '{code: code_reg, count: gst_pkg::CNT_W'(1)};
                        used_next = used_reg + gst_pkg::MISS_CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = gst_pkg::sat_inc(ovf_reg);
                    end
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next  = idx_reg + gst_pkg::MISS_IDX_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + gst_pkg::MISS_IDX_W'(1);
                end
            end

            ST_RDWAIT:
            begin
                evalid_next = 1'b1;
                ecode_next  = ram_rdata.code;
                ecount_next = ram_rdata.count;
                state_next  = ST_FIN;
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= '0;
            code_reg     <= '0;
            glyphs_reg   <= '0;
            slot_reg     <= '0;
            idx_reg      <= '0;
            used_reg     <= '0;
            req_cnt_reg  <= '0;
            miss_tot_reg <= '0;
            ovf_reg      <= '0;
            glyph_reg    <= '0;
            subst_reg    <= 1'b0;
            fatal_reg    <= 1'b0;
            evalid_reg   <= 1'b0;
            ecode_reg    <= '0;
            ecount_reg   <= '0;
            fsize_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            code_reg     <= code_next;
            glyphs_reg   <= glyphs_next;
            slot_reg     <= slot_next;
            idx_reg      <= idx_next;
            used_reg     <= used_next;
            req_cnt_reg  <= req_cnt_next;
            miss_tot_reg <= miss_tot_next;
            ovf_reg      <= ovf_next;
            glyph_reg    <= glyph_next;
            subst_reg    <= subst_next;
            fatal_reg    <= fatal_next;
            evalid_reg   <= evalid_next;
            ecode_reg    <= ecode_next;
            ecount_reg   <= ecount_next;
            fsize_reg    <= fsize_next;
        end
    end

    always_comb
    begin
        res.glyph_index      = glyph_reg;
        res.substituted      = subst_reg;
        res.fatal_miss       = fatal_reg;
        res.drawn_total      = req_cnt_reg;
        res.missing_total    = miss_tot_reg;
        res.missing_distinct = used_reg;
        res.missing_overflow = ovf_reg;
        res.entry_valid      = evalid_reg;
        res.entry_code       = ecode_reg;
        res.entry_count      = ecount_reg;
        res.font_size_value  = fsize_reg;
        res.font_sizes_used  = size_used;
    end

    `GST_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= gst_pkg::MISS_CNT_W'(gst_pkg::MISS_ENTRIES))
    `GST_ASSERT_NEXT(a_used_step, 1'b1, (used_reg - $past(used_reg)) <= gst_pkg::MISS_CNT_W'(1))
    `GST_ASSERT_NOW(a_scan_in_use, state_reg == ST_SCAN, gst_pkg::MISS_CNT_W'(idx_reg) < used_reg)
    `GST_ASSERT_NOW(a_ram_one_op, ram_we, !ram_re)

endmodule

`default_nettype wire

// ===== sv/glyph_substitution_tally_unit.sv =====
// Top level of the glyph substitution tally: stream ports, config registers, output word.
`default_nettype none

// Glyph substitution tally. Each input word is one request, selected by s_tuser (mode):
// mode 0 asks for the glyph of a character code in a font of font_glyphs glyphs and returns
// code-1, or, for code zero, the none code or a code past the font, the substitute code's
// glyph with the miss tallied in a 64-entry table of distinct codes (saturating counts,
// misses past a full table go to an overflow counter); every mode 0 request also records
// its glyph count in an 8-entry set of distinct counts while the set has room. Mode 1
// reads a miss table slot, mode 2 a glyph count slot; mode 3 changes nothing. Every
// output word carries all totals as they stand after the request. Only one request is
// in flight at a time. The miss table sits in a memory with one write port and one
// registered read port, and a miss scans it one entry per clock, then updates the match
// or appends in place; a match ends the scan at its own entry. A finished word waits in
// the output register, and the next request is taken while it waits; only when the
// output register is still full at the end of a request does the block wait for m_tready.
// Configuration is written through cfg_we, cfg_addr (0 substitute code, 1 none code,
// 2 halt on missing) and cfg_wdata; the user must write it only while the block is idle,
// as the block itself does not enforce this. The tables need no clearing after reset:
// only entries below the use counts are ever read.
module glyph_substitution_tally_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [15:0] code, [31:16] font_glyphs, [37:32] slot, [39:38] zero
    input  wire logic [gst_pkg::IN_DATA_W-1:0]      s_tdata,
    // [1:0] mode
    input  wire logic [gst_pkg::MODE_W-1:0]         s_tuser,

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [15:0] glyph_index, [16] substituted, [17] fatal_miss, [49:18] drawn_total,
    // [81:50] missing_total, [88:82] missing_distinct, [120:89] missing_overflow,
    // [121] entry_valid, [137:122] entry_code, [169:138] entry_count,
    // [185:170] font_size_value, [189:186] font_sizes_used, [191:190] zero
    output logic [gst_pkg::OUT_DATA_W-1:0]          m_tdata,

    input  wire logic                               cfg_we,
    input  wire logic [gst_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [gst_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    gst_pkg::cfg_t                   cfg_reg, cfg_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [gst_pkg::OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                            out_free;
    logic                            res_push;
    gst_pkg::result_t                res;

    // config writes: registers beyond the list are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                gst_pkg::CFG_SUBSTITUTE: cfg_next.substitute_code = cfg_wdata;
                gst_pkg::CFG_NONE_CODE:  cfg_next.none_code       = cfg_wdata;
                gst_pkg::CFG_HALT:       cfg_next.halt_on_missing = cfg_wdata[0];
                default:                 cfg_next                 = cfg_reg;
            endcase
        end
    end

    gst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_code   (s_tdata[15:0]),
        .in_glyphs (s_tdata[31:16]),
        .in_slot   (s_tdata[37:32]),
        .cfg       (cfg_reg),
        .out_free  (out_free),
        .res_push  (res_push),
        .res       (res)
    );

    // output register: takes a new word whenever the old one leaves this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_push)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00,
                             res.font_sizes_used,
                             res.font_size_value,
                             res.entry_count,
                             res.entry_code,
                             res.entry_valid,
                             res.missing_overflow,
                             res.missing_distinct,
                             res.missing_total,
                             res.drawn_total,
                             res.fatal_miss,
                             res.substituted,
                             res.glyph_index};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.substitute_code <= gst_pkg::CODE_W'(1);
            cfg_reg.none_code       <= '0;
            cfg_reg.halt_on_missing <= 1'b0;
            m_tvalid_reg            <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
